// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/stb_pkg.sv =====
// Shared types and constants of the source byte tokenizer.
package stb_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int QPTR_BITS = 2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic [7:0]  first_char;
        logic        last_of_run;
    } t_out_req;

    // Up to two records caused by one input byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_req   rec0;
        t_out_req   rec1;
    } t_pair;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== design/stb_scan.sv =====
// Front end: accepts bytes, classifies them and builds token records.
module stb_scan #(
    parameter int POSITION_BITS = stb_pkg::POSITION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  stb_pkg::t_in_req i_req,
    output stb_pkg::t_pair   o_pair,
    output logic             o_push
);

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] DIGIT_LO      = 8'h30;
    localparam logic [7:0] DIGIT_HI      = 8'h39;
    localparam logic [7:0] UPPER_LO      = 8'h41;
    localparam logic [7:0] UPPER_HI      = 8'h5A;
    localparam logic [7:0] LOWER_LO      = 8'h61;
    localparam logic [7:0] LOWER_HI      = 8'h7A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam logic [2:0] KIND_NEWLINE  = 3'd0;
    localparam logic [2:0] KIND_COMMENT  = 3'd1;
    localparam logic [2:0] KIND_SPACE    = 3'd2;
    localparam logic [2:0] KIND_OPERATOR = 3'd3;
    localparam logic [2:0] KIND_STRING   = 3'd4;
    localparam logic [2:0] KIND_NUMBER   = 3'd5;
    localparam logic [2:0] KIND_IDENT    = 3'd6;
    localparam logic [2:0] KIND_ERROR    = 3'd7;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_SKIP
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic [POSITION_BITS-1:0] r_pline, n_pline;
    logic [POSITION_BITS-1:0] r_pcol, n_pcol;
    logic [15:0]              r_plen, n_plen;
    logic [7:0]               r_pfc, n_pfc;

    stb_pkg::t_pair pair;
    logic           do_idle;
    logic           is_digit;
    logic           is_alpha;
    logic [7:0]     c;

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] len_inc(input logic [15:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    function automatic stb_pkg::t_out_req mk_rec(
        input logic [2:0]               kind,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col,
        input logic [15:0]              len,
        input logic [7:0]               fc
    );
        stb_pkg::t_out_req r;
        r.token_kind   = kind;
        r.start_line   = 16'(line);
        r.start_column = 16'(col);
        r.token_length = len;
        r.first_char   = fc;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // Append a record; a third one in the same byte is dropped.
    function automatic stb_pkg::t_pair push_rec(
        input stb_pkg::t_pair   p,
        input stb_pkg::t_out_req r
    );
        stb_pkg::t_pair q;
        q = p;
        case (p.cnt)
            2'd0: begin
                q.rec0 = r;
                q.cnt  = 2'd1;
            end
            2'd1: begin
                q.rec1 = r;
                q.cnt  = 2'd2;
            end
            default: q = p;
        endcase
        return q;
    endfunction

    assign c        = i_req.char_byte;
    assign is_digit = c inside {[DIGIT_LO:DIGIT_HI]};
    assign is_alpha = (c inside {[UPPER_LO:UPPER_HI], [LOWER_LO:LOWER_HI]}) ||
                      (c == CH_UNDERSCORE);

    // Work out next scan state and the records for this byte.
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_pline = r_pline;
        n_pcol  = r_pcol;
        n_plen  = r_plen;
        n_pfc   = r_pfc;
        pair    = '0;
        do_idle = 1'b0;

        // Continue a pending token
        case (r_mode)
            MODE_COMMENT: begin
                if (c == CH_NEWLINE) begin
                    pair    = push_rec(pair, mk_rec(KIND_COMMENT, r_pline, r_pcol,
                                                    r_plen, r_pfc));
                    do_idle = 1'b1;
                end else begin
                    n_col = pos_inc(r_col);
                end
            end
            MODE_STRING: begin
                n_plen = len_inc(r_plen);
                if (c == CH_QUOTE) begin
                    pair   = push_rec(pair, mk_rec(KIND_STRING, r_pline, r_pcol,
                                                   n_plen, r_pfc));
                    n_mode = MODE_IDLE;
                    n_col  = pos_inc(r_col);
                end else if (c == CH_NEWLINE) begin
                    n_line = pos_inc(r_line);
                    n_col  = POS_ONE;
                end else begin
                    n_col = pos_inc(r_col);
                end
            end
            MODE_NUMBER: begin
                if (is_digit) begin
                    n_plen = len_inc(r_plen);
                    n_col  = pos_inc(r_col);
                end else begin
                    pair    = push_rec(pair, mk_rec(KIND_NUMBER, r_pline, r_pcol,
                                                    r_plen, r_pfc));
                    do_idle = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_digit || is_alpha) begin
                    n_plen = len_inc(r_plen);
                    n_col  = pos_inc(r_col);
                end else begin
                    pair    = push_rec(pair, mk_rec(KIND_IDENT, r_pline, r_pcol,
                                                    r_plen, r_pfc));
                    do_idle = 1'b1;
                end
            end
            MODE_SKIP: begin
                n_mode = MODE_SKIP;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Start a new token from idle
        if (do_idle) begin
            n_mode = MODE_IDLE;
            case (c)
                CH_NEWLINE: begin
                    pair   = push_rec(pair, mk_rec(KIND_NEWLINE, r_line, r_col, 16'd0, c));
                    n_line = pos_inc(r_line);
                    n_col  = POS_ONE;
                end
                CH_HASH: begin
                    n_mode  = MODE_COMMENT;
                    n_pline = r_line;
                    n_pcol  = r_col;
                    n_plen  = 16'd0;
                    n_pfc   = c;
                    n_col   = pos_inc(r_col);
                end
                CH_SPACE: begin
                    pair  = push_rec(pair, mk_rec(KIND_SPACE, r_line, r_col, 16'd0, c));
                    n_col = pos_inc(r_col);
                end
                CH_EQUAL, CH_PLUS, CH_MINUS: begin
                    pair  = push_rec(pair, mk_rec(KIND_OPERATOR, r_line, r_col, 16'd1, c));
                    n_col = pos_inc(r_col);
                end
                CH_QUOTE: begin
                    n_mode  = MODE_STRING;
                    n_pline = r_line;
                    n_pcol  = r_col;
                    n_plen  = 16'd1;
                    n_pfc   = c;
                    n_col   = pos_inc(r_col);
                end
                default: begin
                    if (is_digit || is_alpha) begin
                        n_mode  = is_digit ? MODE_NUMBER : MODE_IDENT;
                        n_pline = r_line;
                        n_pcol  = r_col;
                        n_plen  = 16'd1;
                        n_pfc   = c;
                        n_col   = pos_inc(r_col);
                    end else begin
                        pair   = push_rec(pair, mk_rec(KIND_ERROR, r_line, r_col,
                                                       16'd0, c));
                        n_col  = pos_inc(r_col);
                        n_mode = MODE_SKIP;
                    end
                end
            endcase
        end

        // Flush the pending token at end of input and rewind position
        if (i_req.end_of_input) begin
            case (n_mode)
                MODE_COMMENT: pair = push_rec(pair, mk_rec(KIND_COMMENT, n_pline, n_pcol,
                                                           n_plen, n_pfc));
                MODE_NUMBER:  pair = push_rec(pair, mk_rec(KIND_NUMBER, n_pline, n_pcol,
                                                           n_plen, n_pfc));
                MODE_IDENT:   pair = push_rec(pair, mk_rec(KIND_IDENT, n_pline, n_pcol,
                                                           n_plen, n_pfc));
                MODE_STRING:  pair = push_rec(pair, mk_rec(KIND_ERROR, n_pline, n_pcol,
                                                           n_plen, n_pfc));
                default:      pair = pair;
            endcase
            n_mode = MODE_IDLE;
            n_line = POS_ONE;
            n_col  = POS_ONE;
        end

        // Mark the final record of this byte
        case (pair.cnt)
            2'd1:    pair.rec0.last_of_run = 1'b1;
            2'd2:    pair.rec1.last_of_run = 1'b1;
            default: pair = pair;
        endcase
    end

    assign o_pair = pair;
    assign o_push = i_take && (pair.cnt != 2'd0);

    // Hold scan state; advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_pline <= POS_ONE;
            r_pcol  <= POS_ONE;
            r_plen  <= 16'd0;
            r_pfc   <= 8'd0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_pline <= n_pline;
            r_pcol  <= n_pcol;
            r_plen  <= n_plen;
            r_pfc   <= n_pfc;
        end
    end

endmodule

// ===== design/stb_queue.sv =====
// Short queue of record pairs between the scanner and the output stage.
`include "assert_macros.svh"
module stb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stb_pkg::t_q_ctl   i_ctl,
    input  stb_pkg::t_pair    i_pair,
    output stb_pkg::t_pair    o_head,
    output stb_pkg::t_q_stat  o_stat
);

    localparam int PTR_BITS = stb_pkg::QPTR_BITS;
    localparam int DEPTH    = 1 << PTR_BITS;
    localparam logic [PTR_BITS:0] CNT_FULL = (PTR_BITS+1)'(DEPTH);

    stb_pkg::t_pair      r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [PTR_BITS:0]   r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    // Store a pushed pair
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr <= r_wr + PTR_BITS'(1);
            end
            if (i_ctl.pop) begin
                r_rd <= r_rd + PTR_BITS'(1);
            end
            case ({i_ctl.push, i_ctl.pop})
                2'b10:   r_count <= r_count + (PTR_BITS+1)'(1);
                2'b01:   r_count <= r_count - (PTR_BITS+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_ctl.push, !o_stat.full)
    `ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_ctl.pop, !o_stat.empty)
    `ASSERT_IMP(a_ptr_gap, i_clk, i_rst_n, 1'b1, (r_wr - r_rd) == r_count[PTR_BITS-1:0])
    `ASSERT_IMP(a_only_pairs, i_clk, i_rst_n, i_ctl.push, i_pair.cnt != 2'd0)

endmodule

// ===== design/stb_drain.sv =====
// Back end: delivers queued record pairs one record per cycle unless stalled.
`include "assert_macros.svh"
module stb_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stb_pkg::t_pair    i_head,
    input  stb_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output stb_pkg::t_out_req o_req
);

    stb_pkg::t_pair r_pair;
    logic           r_hold;
    logic           r_sel;
    logic           take;
    logic           done;

    assign take  = r_hold && !i_stall;
    // Current pair is finished (or absent): room for the next one
    assign done  = !r_hold || (take && (r_sel || (r_pair.cnt == 2'd1)));
    assign o_pop = done && !i_stat.empty;

    assign o_valid = r_hold;
    assign o_req   = r_sel ? r_pair.rec1 : r_pair.rec0;

    // Load the next pair or step to its second record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_sel  <= 1'b0;
        end else if (done) begin
            r_hold <= !i_stat.empty;
            r_sel  <= 1'b0;
        end else if (take) begin
            r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pair <= i_head;
        end
    end

    `ASSERT_IMP(a_hold_has_rec, i_clk, i_rst_n, r_hold, r_pair.cnt != 2'd0)
    `ASSERT_IMP(a_sel_on_pair, i_clk, i_rst_n, r_sel, r_hold && (r_pair.cnt == 2'd2))
    `ASSERT_NXT(a_second_follows, i_clk, i_rst_n, take && !r_sel && (r_pair.cnt == 2'd2), r_hold && r_sel)

endmodule

// ===== design/source_byte_tokenizer.sv =====
// Top level of the source byte tokenizer: scanner, record queue and output stage.
//
// Takes one source byte per cycle unless stalled and emits token records (newline,
// comment, space, operator, string, number, identifier, error) with start line, column,
// length and first byte. A byte that ends one token and forms another yields two
// records, which the output stage delivers in turn, one record per cycle while the
// output is not stalled. A four-entry queue of record pairs sits between the scanner
// and the output stage, and the input stalls only while that queue is full. An
// accepted byte's records pass through that queue into the output stage.
// Line and column are POSITION_BITS wide internally and saturate at their maximum.
module source_byte_tokenizer #(
    parameter int POSITION_BITS = stb_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  stb_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output stb_pkg::t_out_req o_req
);

    stb_pkg::t_pair   scan_pair;
    stb_pkg::t_pair   q_head;
    stb_pkg::t_q_ctl  q_ctl;
    stb_pkg::t_q_stat q_stat;
    logic             take;
    logic             push;
    logic             pop;

    // Accept a request whenever the queue has room
    assign o_stall = q_stat.full;
    assign take    = i_valid && !q_stat.full;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    stb_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_req),
        .o_pair  (scan_pair),
        .o_push  (push)
    );

    stb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_pair  (scan_pair),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    stb_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_req   (o_req)
    );

endmodule

// ===== test/token_record_checker.sv =====
// Checker for the source byte tokenizer: predicts token records and compares them.
module token_record_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  stb_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  stb_pkg::t_out_req i_out_req,
    output int                o_fail_count,
    output int                o_expected_left
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_COMMENT,
        SCAN_STRING,
        SCAN_NUMBER,
        SCAN_IDENT,
        SCAN_SKIP
    } t_scan_mode;

    typedef enum logic [2:0] {
        TOK_NEWLINE    = 3'd0,
        TOK_COMMENT    = 3'd1,
        TOK_SPACE      = 3'd2,
        TOK_OPERATOR   = 3'd3,
        TOK_STRING     = 3'd4,
        TOK_NUMBER     = 3'd5,
        TOK_IDENT      = 3'd6,
        TOK_ERROR      = 3'd7
    } t_token_kind;

    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_QUOTE      = 8'h22;
    localparam logic [7:0]  CH_HASH       = 8'h23;
    localparam logic [7:0]  CH_PLUS       = 8'h2B;
    localparam logic [7:0]  CH_MINUS      = 8'h2D;
    localparam logic [7:0]  CH_EQUAL      = 8'h3D;
    localparam logic [7:0]  CH_ZERO       = 8'h30;
    localparam logic [7:0]  CH_NINE       = 8'h39;
    localparam logic [7:0]  CH_UPPER_A    = 8'h41;
    localparam logic [7:0]  CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0]  CH_LOWER_A    = 8'h61;
    localparam logic [7:0]  CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0]  CH_UNDERSCORE = 8'h5F;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Scanner state mirrored from the block
    t_scan_mode  mode;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [7:0]  tok_first;

    stb_pkg::t_out_req step_records[$];
    stb_pkg::t_out_req expected_records[$];

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_ident_head(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDERSCORE;
    endfunction

    function automatic void add_record(t_token_kind kind, logic [15:0] line,
                                       logic [15:0] col, logic [15:0] len,
                                       logic [7:0] first);
        stb_pkg::t_out_req r;
        r.token_kind   = kind;
        r.start_line   = line;
        r.start_column = col;
        r.token_length = len;
        r.first_char   = first;
        r.last_of_run  = 1'b0;
        step_records.push_back(r);
    endfunction

    function automatic void close_pending(t_token_kind kind);
        add_record(kind, tok_line, tok_col, tok_len, tok_first);
    endfunction

    function automatic void open_token(t_scan_mode m, logic [7:0] c, logic [15:0] len);
        mode      = m;
        tok_line  = cur_line;
        tok_col   = cur_col;
        tok_len   = len;
        tok_first = c;
        cur_col   = sat_inc(cur_col);
    endfunction

    // Classify a byte seen outside any pending token
    function automatic void start_byte(logic [7:0] c);
        mode = SCAN_IDLE;
        if (c == CH_NEWLINE) begin
            add_record(TOK_NEWLINE, cur_line, cur_col, 16'd0, c);
            cur_line = sat_inc(cur_line);
            cur_col  = 16'd1;
        end else if (c == CH_HASH) begin
            open_token(SCAN_COMMENT, c, 16'd0);
        end else if (c == CH_SPACE) begin
            add_record(TOK_SPACE, cur_line, cur_col, 16'd0, c);
            cur_col = sat_inc(cur_col);
        end else if (c == CH_EQUAL || c == CH_PLUS || c == CH_MINUS) begin
            add_record(TOK_OPERATOR, cur_line, cur_col, 16'd1, c);
            cur_col = sat_inc(cur_col);
        end else if (c == CH_QUOTE) begin
            open_token(SCAN_STRING, c, 16'd1);
        end else if (is_digit(c)) begin
            open_token(SCAN_NUMBER, c, 16'd1);
        end else if (is_ident_head(c)) begin
            open_token(SCAN_IDENT, c, 16'd1);
        end else begin
            // unknown byte: report it, then drop everything until end of input
            add_record(TOK_ERROR, cur_line, cur_col, 16'd0, c);
            cur_col = sat_inc(cur_col);
            mode    = SCAN_SKIP;
        end
    endfunction

    function automatic void reset_scanner();
        mode      = SCAN_IDLE;
        cur_line  = 16'd1;
        cur_col   = 16'd1;
        tok_line  = 16'd1;
        tok_col   = 16'd1;
        tok_len   = 16'd0;
        tok_first = 8'd0;
    endfunction

    // Predict the records caused by one accepted request
    function automatic void scan_byte(stb_pkg::t_in_req req);
        logic [7:0] c;
        c = req.char_byte;
        step_records.delete();
        case (mode)
            SCAN_COMMENT: begin
                if (c == CH_NEWLINE) begin
                    close_pending(TOK_COMMENT);
                    start_byte(c);
                end else begin
                    cur_col = sat_inc(cur_col);
                end
            end
            SCAN_STRING: begin
                tok_len = sat_inc(tok_len);
                if (c == CH_QUOTE) begin
                    close_pending(TOK_STRING);
                    mode    = SCAN_IDLE;
                    cur_col = sat_inc(cur_col);
                end else if (c == CH_NEWLINE) begin
                    cur_line = sat_inc(cur_line);
                    cur_col  = 16'd1;
                end else begin
                    cur_col = sat_inc(cur_col);
                end
            end
            SCAN_NUMBER: begin
                if (is_digit(c)) begin
                    tok_len = sat_inc(tok_len);
                    cur_col = sat_inc(cur_col);
                end else begin
                    close_pending(TOK_NUMBER);
                    start_byte(c);
                end
            end
            SCAN_IDENT: begin
                if (is_digit(c) || is_ident_head(c)) begin
                    tok_len = sat_inc(tok_len);
                    cur_col = sat_inc(cur_col);
                end else begin
                    close_pending(TOK_IDENT);
                    start_byte(c);
                end
            end
            SCAN_SKIP: ;
            default: start_byte(c);
        endcase

        // flush a pending token at end of input and restart position
        if (req.end_of_input) begin
            case (mode)
                SCAN_COMMENT: close_pending(TOK_COMMENT);
                SCAN_NUMBER:  close_pending(TOK_NUMBER);
                SCAN_IDENT:   close_pending(TOK_IDENT);
                SCAN_STRING:  close_pending(TOK_ERROR);
                default: ;
            endcase
            mode     = SCAN_IDLE;
            cur_line = 16'd1;
            cur_col  = 16'd1;
        end

        if (step_records.size() > 0) begin
            step_records[step_records.size() - 1].last_of_run = 1'b1;
        end
        foreach (step_records[i]) begin
            expected_records.push_back(step_records[i]);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("token record field %s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Compare delivered records first, then predict from the accepted request
    always @(posedge i_clk) begin
        stb_pkg::t_out_req want;
        if (!i_rst_n) begin
            reset_scanner();
            expected_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_records.size() == 0) begin
                    $error("token record with none expected: %p", i_out_req);
                    o_fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("token_kind", int'(want.token_kind),
                                int'(i_out_req.token_kind));
                    check_field("start_line", int'(want.start_line),
                                int'(i_out_req.start_line));
                    check_field("start_column", int'(want.start_column),
                                int'(i_out_req.start_column));
                    check_field("token_length", int'(want.token_length),
                                int'(i_out_req.token_length));
                    check_field("first_char", int'(want.first_char),
                                int'(i_out_req.first_char));
                    check_field("last_of_run", int'(want.last_of_run),
                                int'(i_out_req.last_of_run));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_in_req);
            end
        end
        o_expected_left = expected_records.size();
    end

endmodule

// ===== test/source_byte_tokenizer_tb.sv =====
// Testbench top of the source byte tokenizer: clock, reset, source text stimulus, verdict.
module source_byte_tokenizer_tb;

    localparam int RANDOM_ITEMS     = 1850;
    localparam int QUIET_TAIL       = 200;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int HOLD_AT_ITEM     = 600;
    localparam int PAUSE_AT_ITEM    = 1200;
    localparam int DRAIN_CYCLES     = 20;

    localparam string IDENT_HEAD =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz";
    localparam string IDENT_BODY =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz0123456789";
    localparam string DIGITS     = "0123456789";
    localparam string OPERATORS  = "=+-";
    localparam string PUNCT      = "!$%&'()*,./:;<>?@[\\]^{|}~";

    localparam logic [7:0] NEWLINE_CH = "\n";
    localparam logic [7:0] SPACE_CH   = " ";
    localparam logic [7:0] QUOTE_CH   = "\"";
    localparam logic [7:0] HASH_CH    = "#";
    localparam logic [7:0] TILDE_CH   = "~";

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    stb_pkg::t_in_req  i_req;
    logic              o_valid;
    logic              i_stall;
    stb_pkg::t_out_req o_req;

    int fail_count;
    int expected_left;
    int items_sent;
    bit gaps_on;
    bit hold_done;
    bit pause_done;

    source_byte_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_req   (o_req)
    );

    token_record_checker record_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_req        (i_req),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_req       (o_req),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] pick(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // Offer one request; hold it until accepted, return at the next falling edge
    task automatic offer_byte(input logic [7:0] c, input logic eoi);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= '{char_byte: c, end_of_input: eoi};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            offer_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Build one source text from random tokens, end of input on its last byte
    task automatic send_text();
        logic [7:0] text[$];
        logic [7:0] b;
        int roll;
        repeat ($urandom_range(1, 12)) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                text.push_back(pick(IDENT_HEAD));
                repeat ($urandom_range(0, 6)) text.push_back(pick(IDENT_BODY));
            end else if (roll < 35) begin
                repeat ($urandom_range(1, 5)) text.push_back(pick(DIGITS));
            end else if (roll < 50) begin
                text.push_back(SPACE_CH);
            end else if (roll < 62) begin
                text.push_back(pick(OPERATORS));
            end else if (roll < 72) begin
                text.push_back(NEWLINE_CH);
            end else if (roll < 82) begin
                text.push_back(QUOTE_CH);
                repeat ($urandom_range(0, 6)) begin
                    b = ($urandom_range(0, 4) == 0) ? NEWLINE_CH : 8'($urandom_range(0, 255));
                    text.push_back((b == QUOTE_CH) ? SPACE_CH : b);
                end
                text.push_back(QUOTE_CH);
            end else if (roll < 89) begin
                text.push_back(HASH_CH);
                repeat ($urandom_range(0, 8)) begin
                    b = 8'($urandom_range(0, 255));
                    text.push_back((b == NEWLINE_CH) ? TILDE_CH : b);
                end
                text.push_back(NEWLINE_CH);
            end else if (roll < 92) begin
                text.push_back(($urandom_range(0, 1) == 0) ? pick(PUNCT)
                                                           : 8'($urandom_range(128, 255)));
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        // leave a string open at the end now and then
        if ($urandom_range(0, 9) == 0) begin
            text.push_back(QUOTE_CH);
            repeat ($urandom_range(0, 3)) text.push_back(pick(IDENT_BODY));
        end
        foreach (text[i]) begin
            offer_byte(text[i], i == text.size() - 1);
        end
    endtask

    // Output side: random stall bursts and one long hold-off
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_done && !hold_taken) begin
                hold_left  = LONG_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Input side: reset, directed texts, random texts, drain, verdict
    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req      <= '0;
        gaps_on    = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        items_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every token kind but error, two records per byte, string across a line
        send_string("Az_9=42 \"q\n\"-#~\n");
        // number, open string and lone comment closed by end of input
        send_string("12");
        send_string("\"ab");
        send_string("#");
        // unknown byte, then skip up to end of input
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b1);

        while (items_sent < RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= PAUSE_AT_ITEM) begin
                i_valid <= 1'b0;
                do @(negedge i_clk); while (expected_left != 0);
                pause_done = 1'b1;
            end
            gaps_on = (items_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            send_text();
        end

        // drain and report
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("source_byte_tokenizer_tb: clean");
        end else begin
            $display("source_byte_tokenizer_tb: errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("source_byte_tokenizer_tb: errors");
        $finish;
    end

endmodule
